FILE: design/kruskal_union_find_bottleneck_assert.svh
// Assertion macros for the union-find edge acceptor.
`ifndef KRUSKAL_UNION_FIND_BOTTLENECK_ASSERT_SVH
`define KRUSKAL_UNION_FIND_BOTTLENECK_ASSERT_SVH

// Same-cycle implication.
`define KUB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define KUB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/kub_pkg.sv
// Shared constants for the union-find edge acceptor.
`timescale 1ns / 1ps

package kub_pkg;

   localparam int NODE_BITS = 9;

   typedef logic [NODE_BITS-1:0] node_type;

   localparam node_type NODE_COUNT_RESET = 9'd511;

endpackage

FILE: design/kub_channels.sv
// Handshake channel interfaces: edge request, edge result, node count write.
`timescale 1ns / 1ps

interface kub_req_if #(parameter int WEIGHT_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic                   first_edge;
   kub_pkg::node_type      node_a;
   kub_pkg::node_type      node_b;
   logic [WEIGHT_BITS-1:0] weight;

   modport source (output valid, first_edge, node_a, node_b, weight, input ready);
   modport sink   (input valid, first_edge, node_a, node_b, weight, output ready);
endinterface

interface kub_rsp_if #(parameter int WEIGHT_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic                   joined;
   logic [WEIGHT_BITS-1:0] bottleneck;
   logic                   bad_node;

   modport source (output valid, joined, bottleneck, bad_node, input ready);
   modport sink   (input valid, joined, bottleneck, bad_node, output ready);
endinterface

interface kub_csr_if;
   logic              valid;
   logic              ready;
   kub_pkg::node_type data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: design/kruskal_union_find_bottleneck.sv
// Kruskal edge acceptor: union-find parent table in one synchronous RAM.
`timescale 1ns / 1ps
`include "kruskal_union_find_bottleneck_assert.svh"

// Takes one edge at a time and answers with joined, the running bottleneck
// (largest joined weight) and bad_node. The parent table sits in a single
// RAM with one read and one write port and registered read data; both root
// walks and both path-compression passes step through it one parent link
// per clock. Path compression keeps the walk from each endpoint to its root
// short. After reset, and before any edge that carries first_edge, a
// clearing pass rewrites every entry to point to itself; req_ch.ready
// stays low during that pass. Node count writes are always taken and are
// meant to happen only while no edge is in flight.
module kruskal_union_find_bottleneck #(
   parameter int MAX_NODES   = 512,
   parameter int WEIGHT_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   kub_req_if.sink   req_ch,
   kub_rsp_if.source rsp_ch,
   kub_csr_if.sink   csr_ch
);

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int EXT_W = IDX_W + kub_pkg::NODE_BITS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_FIND  = 3'd3;
   localparam logic [2:0] ST_COMP  = 3'd4;
   localparam logic [2:0] ST_LINK  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);
   localparam logic [EXT_W-1:0] MAX_EXT  = EXT_W'(MAX_NODES - 1);

   logic [2:0]             state_ff, state_in;
   logic                   item_ff, item_in;
   kub_pkg::node_type      a_ff, a_in, b_ff, b_in;
   logic [WEIGHT_BITS-1:0] w_ff, w_in;
   logic                   side_ff, side_in;
   logic [IDX_W-1:0]       cur_ff, cur_in;
   logic [IDX_W-1:0]       root_a_ff, root_a_in, root_b_ff, root_b_in;
   logic [IDX_W-1:0]       clr_idx_ff, clr_idx_in;
   logic                   joined_ff, joined_in, bad_ff, bad_in;
   logic [WEIGHT_BITS-1:0] largest_ff, largest_in;
   kub_pkg::node_type      node_count_ff, node_count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_joined_ff, rsp_joined_in;
   logic                   rsp_bad_ff, rsp_bad_in;
   logic [WEIGHT_BITS-1:0] rsp_bottleneck_ff, rsp_bottleneck_in;

   // parent table
   logic [IDX_W-1:0] table_mem [MAX_NODES];
   logic [IDX_W-1:0] rd_data_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr, mem_wdata, mem_raddr;

   logic             req_accept;
   logic [EXT_W-1:0] a_ext, b_ext, cnt_ext, limit_ext;
   logic [IDX_W-1:0] a_idx, b_idx, cur_root;
   logic             bad_edge;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.joined     = rsp_joined_ff;
   assign rsp_ch.bottleneck = rsp_bottleneck_ff;
   assign rsp_ch.bad_node   = rsp_bad_ff;

   assign a_ext     = {{IDX_W{1'b0}}, a_ff};
   assign b_ext     = {{IDX_W{1'b0}}, b_ff};
   assign cnt_ext   = {{IDX_W{1'b0}}, node_count_ff};
   assign limit_ext = (cnt_ext > MAX_EXT) ? MAX_EXT : cnt_ext;
   assign a_idx     = a_ext[IDX_W-1:0];
   assign b_idx     = b_ext[IDX_W-1:0];
   assign bad_edge  = (a_ff == '0) || (b_ff == '0) || (a_ext > limit_ext) ||
                      (b_ext > limit_ext);
   assign cur_root  = side_ff ? root_b_ff : root_a_ff;

   always_comb begin
      state_in          = state_ff;
      item_in           = item_ff;
      a_in              = a_ff;
      b_in              = b_ff;
      w_in              = w_ff;
      side_in           = side_ff;
      cur_in            = cur_ff;
      root_a_in         = root_a_ff;
      root_b_in         = root_b_ff;
      clr_idx_in        = clr_idx_ff;
      joined_in         = joined_ff;
      bad_in            = bad_ff;
      largest_in        = largest_ff;
      node_count_in     = node_count_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_joined_in     = rsp_joined_ff;
      rsp_bad_in        = rsp_bad_ff;
      rsp_bottleneck_in = rsp_bottleneck_ff;
      mem_we            = 1'b0;
      mem_waddr         = cur_ff;
      mem_wdata         = cur_root;
      mem_raddr         = cur_ff;

      if (csr_ch.valid) begin
         node_count_in = csr_ch.data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in    = 1'b1;
               a_in       = req_ch.node_a;
               b_in       = req_ch.node_b;
               w_in       = req_ch.weight;
               clr_idx_in = '0;
               if (req_ch.first_edge) begin
                  largest_in = '0;
                  state_in   = ST_CLEAR;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = clr_idx_ff;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_IDX) begin
               state_in = item_ff ? ST_CHECK : ST_IDLE;
            end
         end
         ST_CHECK: begin
            joined_in = 1'b0;
            bad_in    = bad_edge;
            side_in   = 1'b0;
            cur_in    = a_idx;
            mem_raddr = a_idx;
            state_in  = bad_edge ? ST_DONE : ST_FIND;
         end
         ST_FIND: begin
            // rd_data_ff holds parent of cur_ff
            if (rd_data_ff == cur_ff) begin
               if (side_ff) begin
                  root_b_in = cur_ff;
               end else begin
                  root_a_in = cur_ff;
               end
               cur_in    = side_ff ? b_idx : a_idx;
               mem_raddr = side_ff ? b_idx : a_idx;
               state_in  = ST_COMP;
            end else begin
               cur_in    = rd_data_ff;
               mem_raddr = rd_data_ff;
            end
         end
         ST_COMP: begin
            if (cur_ff == cur_root) begin
               if (side_ff) begin
                  state_in = ST_LINK;
               end else begin
                  side_in   = 1'b1;
                  cur_in    = b_idx;
                  mem_raddr = b_idx;
                  state_in  = ST_FIND;
               end
            end else begin
               // point this node at the root, move on to its old parent
               mem_we    = 1'b1;
               mem_waddr = cur_ff;
               mem_wdata = cur_root;
               cur_in    = rd_data_ff;
               mem_raddr = rd_data_ff;
            end
         end
         ST_LINK: begin
            if (root_a_ff != root_b_ff) begin
               mem_we    = 1'b1;
               mem_waddr = root_a_ff;
               mem_wdata = root_b_ff;
               joined_in = 1'b1;
               if (largest_ff < w_ff) begin
                  largest_in = w_ff;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in      = 1'b1;
               rsp_joined_in     = joined_ff;
               rsp_bad_in        = bad_ff;
               rsp_bottleneck_in = largest_ff;
               item_in           = 1'b0;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      // write-through so a read of the entry being written sees the new value
      if (mem_we && (mem_waddr == mem_raddr)) begin
         rd_data_ff <= mem_wdata;
      end else begin
         rd_data_ff <= table_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         item_ff       <= 1'b0;
         clr_idx_ff    <= '0;
         largest_ff    <= '0;
         node_count_ff <= kub_pkg::NODE_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         item_ff       <= item_in;
         clr_idx_ff    <= clr_idx_in;
         largest_ff    <= largest_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff              <= a_in;
      b_ff              <= b_in;
      w_ff              <= w_in;
      side_ff           <= side_in;
      cur_ff            <= cur_in;
      root_a_ff         <= root_a_in;
      root_b_ff         <= root_b_in;
      joined_ff         <= joined_in;
      bad_ff            <= bad_in;
      rsp_joined_ff     <= rsp_joined_in;
      rsp_bad_ff        <= rsp_bad_in;
      rsp_bottleneck_ff <= rsp_bottleneck_in;
   end

   `KUB_ASSERT_NOW(a_bad_not_joined, clock, reset, rsp_valid_ff && rsp_bad_ff, !rsp_joined_ff, "bad edge reported as joined")
   `KUB_ASSERT_NOW(a_comp_not_root, clock, reset, (state_ff == ST_COMP) && mem_we, mem_waddr != cur_root, "compression rewrote a root")
   `KUB_ASSERT_NOW(a_bottleneck_covers, clock, reset, (state_ff == ST_DONE) && joined_ff, largest_ff >= w_ff, "bottleneck below joined weight")
   `KUB_ASSERT_NEXT(a_largest_hold, clock, reset, (state_ff != ST_LINK) && !(req_accept && req_ch.first_edge), $stable(largest_ff), "bottleneck changed outside a link or clear")

endmodule

FILE: sim/tb_top.sv
// Testbench for the Kruskal union-find edge acceptor: random edge streams vs. a predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_NODES   = 512;
   localparam int WEIGHT_BITS = 16;
   localparam int STALL_LIMIT = 20000;
   localparam int TAIL_CYCLES = 64;
   localparam int HOLD_AFTER  = 350;
   localparam int HOLD_CYCLES = 400;

   typedef logic [WEIGHT_BITS-1:0] weight_type;

   typedef struct {
      logic              first;
      kub_pkg::node_type a;
      kub_pkg::node_type b;
      weight_type        w;
      bit                drain;   // hold this item back until every result is in
   } arc_type;

   typedef struct {
      logic       joined;
      weight_type bottleneck;
      logic       bad;
   } verdict_type;

   typedef enum logic [1:0] {
      TAKE_ALL, TAKE_COIN, TAKE_PERIODIC, TAKE_MOSTLY
   } take_mode_type;

   logic clock = 1'b0;
   logic reset;

   kub_req_if #(.WEIGHT_BITS(WEIGHT_BITS)) req_ch ();
   kub_rsp_if #(.WEIGHT_BITS(WEIGHT_BITS)) rsp_ch ();
   kub_csr_if csr_ch ();

   kruskal_union_find_bottleneck #(
      .MAX_NODES  (MAX_NODES),
      .WEIGHT_BITS(WEIGHT_BITS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // predictor state
   kub_pkg::node_type parent_tbl [MAX_NODES];
   weight_type        widest;
   kub_pkg::node_type node_count = kub_pkg::NODE_COUNT_RESET;

   arc_type     arc_q[$];
   verdict_type verdict_q[$];
   int unsigned results_seen;
   int unsigned fail_count;

   always #4 clock = ~clock;

   function automatic void clear_forest();
      for (int i = 0; i < MAX_NODES; i++) parent_tbl[i] = kub_pkg::node_type'(i);
      widest = '0;
   endfunction

   function automatic kub_pkg::node_type find_root(kub_pkg::node_type v);
      kub_pkg::node_type r;
      kub_pkg::node_type nxt;
      int                steps;
      r = v;
      steps = 0;
      while (parent_tbl[r] != r && steps < MAX_NODES) begin
         r = parent_tbl[r];
         steps++;
      end
      // path compression: point every node on the walk straight at the root
      steps = 0;
      while (v != r && steps < MAX_NODES) begin
         nxt = parent_tbl[v];
         parent_tbl[v] = r;
         v = nxt;
         steps++;
      end
      return r;
   endfunction

   function automatic verdict_type kruskal_accept(arc_type x);
      verdict_type       v;
      kub_pkg::node_type ra;
      kub_pkg::node_type rb;
      v.joined = 1'b0;
      v.bad    = 1'b0;
      if (x.first) clear_forest();
      if (x.a == 0 || x.b == 0 || x.a > node_count || x.b > node_count) begin
         v.bad = 1'b1;
      end else begin
         ra = find_root(x.a);
         rb = find_root(x.b);
         if (ra != rb) begin
            parent_tbl[ra] = rb;
            v.joined = 1'b1;
            if (widest < x.w) widest = x.w;
         end
      end
      v.bottleneck = widest;
      return v;
   endfunction

   // ---------------- driver ----------------
   int unsigned burst_left;
   int unsigned gap_left;

   always @(posedge clock) begin
      bit took;
      bit offer;
      if (reset) begin
         req_ch.valid      <= 1'b0;
         req_ch.first_edge <= 1'b0;
         req_ch.node_a     <= '0;
         req_ch.node_b     <= '0;
         req_ch.weight     <= '0;
         burst_left = 0;
         gap_left = 0;
         clear_forest();
      end else begin
         took = req_ch.valid && req_ch.ready;
         if (took) begin
            verdict_q.insert(verdict_q.size(), kruskal_accept(arc_q[0]));
            void'(arc_q.pop_front());
         end
         if (!req_ch.valid || took) begin
            if (burst_left == 0) begin
               case ($urandom_range(2, 0))
                  0: begin
                     burst_left = $urandom_range(200, 30);
                     gap_left = 0;
                  end
                  1: begin
                     burst_left = $urandom_range(4, 1);
                     gap_left = $urandom_range(3, 0);
                  end
                  default: begin
                     burst_left = $urandom_range(8, 1);
                     gap_left = $urandom_range(25, 1);
                  end
               endcase
            end
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (arc_q.size() > 0 &&
                         (!arc_q[0].drain || verdict_q.size() == 0)) begin
               offer = 1'b1;
               burst_left--;
            end
            req_ch.valid <= offer;
            if (offer) begin
               req_ch.first_edge <= arc_q[0].first;
               req_ch.node_a     <= arc_q[0].a;
               req_ch.node_b     <= arc_q[0].b;
               req_ch.weight     <= arc_q[0].w;
            end
         end
      end
   end

   // ---------------- receiver ----------------
   take_mode_type take_mode;
   int unsigned   mode_left;
   int unsigned   hold_left;
   bit            hold_done;
   int unsigned   take_phase;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         mode_left = 0;
         hold_left = 0;
         hold_done = 1'b0;
         take_phase = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         // long back-pressure so the block fills and stalls its input
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            take_mode = take_mode_type'($urandom_range(3, 0));
            mode_left = $urandom_range(150, 20);
         end
         mode_left--;
         take_phase++;
         case (take_mode)
            TAKE_ALL:      rsp_ch.ready <= 1'b1;
            TAKE_COIN:     rsp_ch.ready <= ($urandom_range(1, 0) == 1);
            TAKE_PERIODIC: rsp_ch.ready <= (take_phase % 4 == 3);
            default:       rsp_ch.ready <= ($urandom_range(7, 0) != 0);
         endcase
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      verdict_type exp_v;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (verdict_q.size() == 0) begin
            $error("unexpected result item: joined %0d bottleneck %0d bad_node %0d",
                   rsp_ch.joined, rsp_ch.bottleneck, rsp_ch.bad_node);
            fail_count++;
         end else begin
            exp_v = verdict_q.pop_front();
            if (rsp_ch.joined !== exp_v.joined) begin
               $error("joined: expected %0d, got %0d", exp_v.joined, rsp_ch.joined);
               fail_count++;
            end
            if (rsp_ch.bottleneck !== exp_v.bottleneck) begin
               $error("bottleneck: expected %0d, got %0d",
                      exp_v.bottleneck, rsp_ch.bottleneck);
               fail_count++;
            end
            if (rsp_ch.bad_node !== exp_v.bad) begin
               $error("bad_node: expected %0d, got %0d", exp_v.bad, rsp_ch.bad_node);
               fail_count++;
            end
         end
      end
   end

   // ---------------- watchdog ----------------
   int unsigned quiet_cycles;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("kruskal_union_find_bottleneck verification failed");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic push_arc(input logic first, input int a, input int b, input int w);
      arc_type x;
      x.first = first;
      x.a     = kub_pkg::node_type'(a);
      x.b     = kub_pkg::node_type'(b);
      x.w     = weight_type'(w);
      x.drain = 1'b0;
      arc_q.insert(arc_q.size(), x);
   endtask

   task automatic wait_idle();
      while (arc_q.size() != 0 || req_ch.valid || verdict_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_node_count(input kub_pkg::node_type value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      node_count = value;
      csr_ch.valid <= 1'b0;
   endtask

   // well-formed spanning-tree runs with random content, mixed with noise items
   task automatic gen_phase(input kub_pkg::node_type cnt, input int n_items);
      int      made;
      int      seq;
      int      n;
      int      len;
      int      step;
      int      w;
      int      pick;
      arc_type x;
      made = 0;
      seq = 0;
      while (made < n_items) begin
         if (cnt == 0 || $urandom_range(99, 0) < 15) begin
            len = $urandom_range(6, 1);
            if (len > n_items - made) len = n_items - made;
            repeat (len) begin
               x.first = ($urandom_range(9, 0) == 0);
               x.a = kub_pkg::node_type'(($urandom_range(3, 0) == 0 && cnt != 0) ?
                                         $urandom_range(cnt, 1) : $urandom_range(511, 0));
               x.b = kub_pkg::node_type'(($urandom_range(3, 0) == 0 && cnt != 0) ?
                                         $urandom_range(cnt, 1) : $urandom_range(511, 0));
               x.w = weight_type'($urandom_range(65535, 0));
               x.drain = 1'b0;
               arc_q.insert(arc_q.size(), x);
               made++;
            end
         end else begin
            pick = $urandom_range(19, 0);
            if (pick < 14)      n = $urandom_range((cnt < 24) ? cnt : 24, 1);
            else if (pick < 19) n = $urandom_range((cnt < 128) ? cnt : 128, 1);
            else                n = cnt;
            len = $urandom_range((2 * n < 60) ? 2 * n : 60, 1);
            if (len > n_items - made) len = n_items - made;
            case ($urandom_range(3, 0))
               0:       step = 0;
               1:       step = 3;
               2:       step = 300;
               default: step = 5000;
            endcase
            w = ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0)
                                            : $urandom_range(200, 0);
            for (int i = 0; i < len; i++) begin
               // the first run of a phase may skip the clear: count changed on a live table
               x.first = (i == 0) && !(seq == 0 && $urandom_range(1, 0) == 0);
               x.drain = x.first && (seq == 2 || $urandom_range(3, 0) == 0);
               if ($urandom_range(19, 0) == 0) begin
                  x.a = kub_pkg::node_type'($urandom_range(511, 0));
                  x.b = kub_pkg::node_type'($urandom_range(n, 1));
               end else begin
                  x.a = kub_pkg::node_type'($urandom_range(n, 1));
                  x.b = kub_pkg::node_type'($urandom_range(n, 1));
               end
               w = w + $urandom_range(step, 0);
               if (w > 65535) w = 65535;
               x.w = weight_type'(w);
               arc_q.insert(arc_q.size(), x);
               made++;
            end
            seq++;
         end
      end
   endtask

   kub_pkg::node_type phase_count [10] = '{9'd1, 9'd0, 9'd511, 9'd4, 9'd17, 9'd255, 9'd2,
                                           9'd100, 9'd511, 9'd0};

   initial begin
      reset = 1'b1;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      phase_count[9] = kub_pkg::node_type'($urandom_range(511, 1));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset table, extremes, bad endpoints, clear on a bad edge
      push_arc(0, 1, 2, 0);
      push_arc(0, 2, 1, 5);
      push_arc(0, 3, 3, 5);
      push_arc(0, 0, 1, 5);
      push_arc(0, 1, 0, 5);
      push_arc(0, 511, 510, 100);
      push_arc(0, 511, 1, 65535);
      push_arc(1, 0, 0, 7);
      push_arc(0, 1, 511, 65535);
      // long chain, then a walk over it that compresses the path
      push_arc(1, 2, 3, 10);
      for (int k = 3; k <= 8; k++) push_arc(0, k, k + 1, 10 + k);
      push_arc(0, 2, 9, 40);
      push_arc(0, 9, 2, 40);
      wait_idle();

      // smaller count without a clear: old links remain
      write_node_count(9'd4);
      push_arc(0, 5, 1, 50);
      push_arc(0, 4, 3, 50);
      push_arc(0, 1, 4, 60);
      push_arc(0, 4, 4, 60);
      push_arc(0, 511, 1, 70);
      wait_idle();

      for (int p = 0; p < 10; p++) begin
         write_node_count(phase_count[p]);
         gen_phase(phase_count[p], (phase_count[p] < 2) ? 60 : 150);
         wait_idle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("kruskal_union_find_bottleneck verification clean");
      else
         $display("kruskal_union_find_bottleneck verification failed");
      $finish;
   end

endmodule
